FILE: rtl/core/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and helpers for the differential-drive odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

  // Fixed-point layout.
  localparam int FRAC_BITS   = 16;
  localparam int ANGLE_BITS  = 18;
  localparam int ATAN_DEPTH  = 24;

  // Port widths.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_DATA_W   = 128;
  localparam int OUT_DATA_W  = 248;

  // 1/(4 pi) in Q0.32 and the CORDIC start value (gain compensated, Q1.16).
  localparam logic [30:0]        INV_FOUR_PI = 31'd341782638;
  localparam logic signed [19:0] CORDIC_X0   = 20'sd39796;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HALF_WHEELBASE   = 3'd0,
    REG_INVERSE_RADIUS   = 3'd1,
    REG_HALF_RADIUS      = 3'd2,
    REG_RADIUS_OVER_BASE = 3'd3,
    REG_TICKS_PER_SECOND = 3'd4,
    REG_TIMEOUT_TICKS    = 3'd5,
    REG_SENSORS_PRESENT  = 3'd6
  } cfg_reg_t;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_CMD_P,
    OP_CMD_L,
    OP_CMD_R,
    OP_CMD_DONE,
    OP_TICK_PREP,
    OP_TRANS,
    OP_ROT,
    OP_UNITS,
    OP_FWD,
    OP_ANG,
    OP_MID,
    OP_POS_X,
    OP_POS_Y,
    OP_HEAD,
    OP_QUAT,
    OP_LOAD
  } op_t;

  typedef struct packed {
    op_t op;
  } ddo_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic cordic_done;
    logic out_busy;
  } ddo_status_t;

  // Arctangent of 2^-i as a binary angle, full circle = 2^32.
  function automatic logic [31:0] atan_at(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > 65'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -65'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/ddo_cordic.sv
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, saturated
// cosine and sine in Q1.16.
// ----------------------------------------------------------------------------
module ddo_cordic #(
  parameter int STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [ddo_pkg::ANGLE_BITS-1:0]    angle,
  output logic                              done,
  output logic signed [17:0]                cos_out,
  output logic signed [17:0]                sin_out
);

  localparam int ITERS = (STEPS < ddo_pkg::ATAN_DEPTH) ? STEPS : ddo_pkg::ATAN_DEPTH;
  localparam int CNT_W = $clog2(ITERS + 1);

  logic                    busy;
  logic [CNT_W-1:0]        cnt;
  logic signed [19:0]      x;
  logic signed [19:0]      y;
  logic signed [33:0]      z;
  logic                    flip;

  logic [31:0]             a_full;
  logic                    a_flip;
  logic [31:0]             a_fold;
  logic signed [19:0]      x_sh;
  logic signed [19:0]      y_sh;
  logic signed [33:0]      atan_v;
  logic signed [20:0]      x_fin;
  logic signed [20:0]      y_fin;

  // Fold the angle into the right half plane; the fold is undone at the end.
  always_comb begin
    a_full = {angle, {(32 - ddo_pkg::ANGLE_BITS){1'b0}}};
    a_flip = a_full[31] ^ a_full[30];
    a_fold = {a_full[31] ^ a_flip, a_full[30:0]};
    x_sh   = x >>> cnt;
    y_sh   = y >>> cnt;
    atan_v = 34'($signed({1'b0, ddo_pkg::atan_at(5'(cnt))}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        x    <= ddo_pkg::CORDIC_X0;
        y    <= '0;
        z    <= 34'($signed(a_fold));
        flip <= a_flip;
      end else if (busy) begin
        if (!z[33]) begin
          x <= x - y_sh;
          y <= y + x_sh;
          z <= z - atan_v;
        end else begin
          x <= x + y_sh;
          y <= y - x_sh;
          z <= z + atan_v;
        end
        if (cnt == CNT_W'(ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // Undo the fold and clamp to plus or minus one.
  always_comb begin
    x_fin = flip ? -21'(x) : 21'(x);
    y_fin = flip ? -21'(y) : 21'(y);
    if (x_fin > 21'sd65536) begin
      cos_out = 18'sd65536;
    end else if (x_fin < -21'sd65536) begin
      cos_out = -18'sd65536;
    end else begin
      cos_out = x_fin[17:0];
    end
    if (y_fin > 21'sd65536) begin
      sin_out = 18'sd65536;
    end else if (y_fin < -21'sd65536) begin
      sin_out = -18'sd65536;
    end else begin
      sin_out = y_fin[17:0];
    end
  end

  // A start is never issued while a rotation is running.
  a_no_restart: assert property (@(posedge clk) disable iff (rst) busy |-> !start)
    else $error("cordic restarted while busy");

endmodule

FILE: rtl/core/ddo_datapath.sv
// ----------------------------------------------------------------------------
// ddo_datapath
// Registers, shared multiplier, CORDIC unit and output register of the
// odometry block; each cycle does what the controller's operation selects.
// ----------------------------------------------------------------------------
module ddo_datapath #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ddo_pkg::ddo_cmd_t                   cmd,
  output ddo_pkg::ddo_status_t                status,
  input  logic                                s_tuser,
  input  logic [ddo_pkg::IN_DATA_W-1:0]       s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ddo_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                m_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ddo_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Configuration registers.
  logic [15:0] half_wheelbase;
  logic [23:0] inverse_radius;
  logic [15:0] half_radius;
  logic [23:0] radius_over_base;
  logic [9:0]  ticks_per_second;
  logic [15:0] timeout_ticks;
  logic [1:0]  sensors_present;

  // Captured item.
  logic               in_kind;
  logic signed [31:0] in_speed;
  logic signed [31:0] in_turn;
  logic [31:0]        in_left;
  logic [31:0]        in_right;

  // Block state.
  logic [31:0]        left_previous;
  logic [31:0]        right_previous;
  logic               left_seen;
  logic               right_seen;
  logic [31:0]        position_x;
  logic [31:0]        position_y;
  logic [17:0]        heading;
  logic signed [31:0] target_left;
  logic signed [31:0] target_right;
  logic [15:0]        ticks_since_command;
  logic signed [31:0] last_forward_velocity;
  logic signed [31:0] last_angular_velocity;

  // Working registers.
  logic signed [31:0] left_step;
  logic signed [31:0] right_step;
  logic signed [32:0] half_turn;
  logic signed [32:0] trans;
  logic signed [31:0] rot_sat;
  logic               rot_big;
  logic               rot_neg;
  logic [17:0]        units;
  logic [17:0]        mid;
  logic               expired;
  logic signed [64:0] prod;

  logic signed [33:0] mul_a;
  logic signed [30:0] mul_b;
  logic signed [64:0] mul_p;
  logic signed [32:0] p_now;
  logic signed [64:0] prod_q;
  logic [15:0]        ticks_inc;

  logic               cordic_start;
  logic [17:0]        cordic_angle;
  logic               cordic_done;
  logic signed [17:0] cordic_cos;
  logic signed [17:0] cordic_sin;

  ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .angle   (cordic_angle),
    .done    (cordic_done),
    .cos_out (cordic_cos),
    .sin_out (cordic_sin)
  );

  assign cfg_ready          = 1'b1;
  assign status.is_tick     = in_kind;
  assign status.cordic_done = cordic_done;
  assign status.out_busy    = m_tvalid & ~m_tready;

  assign p_now     = prod[48:16];
  assign prod_q    = prod >>> ddo_pkg::FRAC_BITS;
  assign ticks_inc = (ticks_since_command != 16'hFFFF) ? ticks_since_command + 16'd1
                                                       : ticks_since_command;

  // CORDIC requests: midpoint heading (doubled) and the half-heading quaternion.
  assign cordic_start = (cmd.op == ddo_pkg::OP_MID) || (cmd.op == ddo_pkg::OP_QUAT);
  assign cordic_angle = (cmd.op == ddo_pkg::OP_MID) ? {mid[16:0], 1'b0} : heading;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      ddo_pkg::OP_CMD_P: begin
        mul_a = 34'(in_turn);
        mul_b = 31'(half_wheelbase);
      end
      ddo_pkg::OP_CMD_L: begin
        mul_a = 34'(in_speed) - 34'(p_now);
        mul_b = 31'(inverse_radius);
      end
      ddo_pkg::OP_CMD_R: begin
        mul_a = 34'(in_speed) + 34'(half_turn);
        mul_b = 31'(inverse_radius);
      end
      ddo_pkg::OP_TRANS: begin
        mul_a = 34'(left_step) + 34'(right_step);
        mul_b = 31'(half_radius);
      end
      ddo_pkg::OP_ROT: begin
        mul_a = 34'(right_step) - 34'(left_step);
        mul_b = 31'(radius_over_base);
      end
      ddo_pkg::OP_UNITS: begin
        mul_a = 34'(ddo_pkg::sat32(prod_q));
        mul_b = 31'(ddo_pkg::INV_FOUR_PI);
      end
      ddo_pkg::OP_FWD: begin
        mul_a = 34'(trans);
        mul_b = 31'(ticks_per_second);
      end
      ddo_pkg::OP_ANG: begin
        mul_a = 34'(rot_sat);
        mul_b = 31'(ticks_per_second);
      end
      ddo_pkg::OP_POS_X: begin
        mul_a = 34'(trans);
        mul_b = 31'(cordic_cos);
      end
      ddo_pkg::OP_POS_Y: begin
        mul_a = 34'(trans);
        mul_b = 31'(cordic_sin);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_wheelbase   <= 16'd2949;
      inverse_radius   <= 24'd2621440;
      half_radius      <= 16'd819;
      radius_over_base <= 24'd18204;
      ticks_per_second <= 10'd5;
      timeout_ticks    <= 16'd5;
      sensors_present  <= 2'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        ddo_pkg::REG_HALF_WHEELBASE:   half_wheelbase   <= cfg_data[15:0];
        ddo_pkg::REG_INVERSE_RADIUS:   inverse_radius   <= cfg_data;
        ddo_pkg::REG_HALF_RADIUS:      half_radius      <= cfg_data[15:0];
        ddo_pkg::REG_RADIUS_OVER_BASE: radius_over_base <= cfg_data;
        ddo_pkg::REG_TICKS_PER_SECOND: ticks_per_second <= cfg_data[9:0];
        ddo_pkg::REG_TIMEOUT_TICKS:    timeout_ticks    <= cfg_data[15:0];
        ddo_pkg::REG_SENSORS_PRESENT:  sensors_present  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Working registers without reset.
  always_ff @(posedge clk) begin
    prod <= mul_p;
    case (cmd.op)
      ddo_pkg::OP_CAPTURE: begin
        in_kind  <= s_tuser;
        in_speed <= s_tdata[31:0];
        in_turn  <= s_tdata[63:32];
        in_left  <= s_tdata[95:64];
        in_right <= s_tdata[127:96];
      end
      ddo_pkg::OP_CMD_L:  half_turn <= p_now;
      ddo_pkg::OP_TICK_PREP: begin
        left_step  <= (sensors_present[0] && left_seen)  ? in_left - left_previous   : '0;
        right_step <= (sensors_present[1] && right_seen) ? in_right - right_previous : '0;
      end
      ddo_pkg::OP_ROT:    trans <= prod[48:16];
      ddo_pkg::OP_UNITS: begin
        rot_sat <= ddo_pkg::sat32(prod_q);
        rot_big <= (prod_q != 65'(ddo_pkg::sat32(prod_q)));
        rot_neg <= prod[64];
      end
      ddo_pkg::OP_FWD: begin
        units <= prod[47:30];
        mid   <= heading + prod[48:31];
      end
      default: ;
    endcase
  end

  // Block state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_previous         <= '0;
      right_previous        <= '0;
      left_seen             <= 1'b0;
      right_seen            <= 1'b0;
      position_x            <= '0;
      position_y            <= '0;
      heading               <= '0;
      target_left           <= '0;
      target_right          <= '0;
      ticks_since_command   <= '0;
      last_forward_velocity <= '0;
      last_angular_velocity <= '0;
      expired               <= 1'b0;
      m_tvalid              <= 1'b0;
    end else begin
      // A pending beat stays until taken; a load refills the register.
      if (cmd.op == ddo_pkg::OP_LOAD) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (cmd.op)
        ddo_pkg::OP_CMD_R: target_left <= ddo_pkg::sat32(prod_q);
        ddo_pkg::OP_CMD_DONE: begin
          target_right        <= ddo_pkg::sat32(prod_q);
          ticks_since_command <= '0;
          expired             <= 1'b0;
        end
        ddo_pkg::OP_TICK_PREP: begin
          ticks_since_command <= ticks_inc;
          expired             <= (ticks_inc > timeout_ticks);
          if (ticks_inc > timeout_ticks) begin
            target_left  <= '0;
            target_right <= '0;
          end
          if (sensors_present[0]) begin
            left_previous <= in_left;
            left_seen     <= 1'b1;
          end
          if (sensors_present[1]) begin
            right_previous <= in_right;
            right_seen     <= 1'b1;
          end
        end
        ddo_pkg::OP_ANG: last_forward_velocity <= ddo_pkg::sat32(prod);
        ddo_pkg::OP_MID: begin
          // A rotation outside 32 bits saturates unless the tick rate is zero.
          if (!rot_big) begin
            last_angular_velocity <= ddo_pkg::sat32(prod);
          end else if (ticks_per_second == '0) begin
            last_angular_velocity <= '0;
          end else begin
            last_angular_velocity <= rot_neg ? 32'sh80000000 : 32'sh7FFFFFFF;
          end
        end
        ddo_pkg::OP_POS_Y: position_x <= position_x + prod[47:16];
        ddo_pkg::OP_HEAD: begin
          position_y <= position_y + prod[47:16];
          heading    <= heading + units;
        end
        ddo_pkg::OP_LOAD: begin
          m_tuser  <= in_kind;
          m_tdata  <= {1'b0, last_angular_velocity, last_forward_velocity, cordic_cos,
                       cordic_sin, heading, position_y, position_x, expired & in_kind,
                       target_right, target_left};
        end
        default: ;
      endcase
    end
  end

  // Heading only moves in its own update step.
  a_heading_hold: assert property (@(posedge clk) disable iff (rst)
      (cmd.op != ddo_pkg::OP_HEAD) |=> $stable(heading))
    else $error("heading changed outside its update step");

  // A command result never reports a timeout.
  a_cmd_not_expired: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && !m_tuser) |-> !m_tdata[64])
    else $error("command result flagged as expired");

endmodule

FILE: rtl/core/ddo_ctrl.sv
// ----------------------------------------------------------------------------
// ddo_ctrl
// Controller state machine: sequences the datapath operations for one item.
// ----------------------------------------------------------------------------
module ddo_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  ddo_pkg::ddo_status_t   status,
  output ddo_pkg::ddo_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_CMD_P,
    S_CMD_L,
    S_CMD_R,
    S_CMD_DONE,
    S_TICK_PREP,
    S_TRANS,
    S_ROT,
    S_UNITS,
    S_FWD,
    S_ANG,
    S_MID,
    S_MID_WAIT,
    S_POS_X,
    S_POS_Y,
    S_HEAD,
    S_QUAT,
    S_QUAT_WAIT,
    S_LOAD
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  // Operation and next state for the current step.
  always_comb begin
    state_next = state;
    cmd.op     = ddo_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = ddo_pkg::OP_CAPTURE;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH:  state_next = status.is_tick ? S_TICK_PREP : S_CMD_P;
      S_CMD_P:     begin cmd.op = ddo_pkg::OP_CMD_P;     state_next = S_CMD_L;     end
      S_CMD_L:     begin cmd.op = ddo_pkg::OP_CMD_L;     state_next = S_CMD_R;     end
      S_CMD_R:     begin cmd.op = ddo_pkg::OP_CMD_R;     state_next = S_CMD_DONE;  end
      S_CMD_DONE:  begin cmd.op = ddo_pkg::OP_CMD_DONE;  state_next = S_QUAT;      end
      S_TICK_PREP: begin cmd.op = ddo_pkg::OP_TICK_PREP; state_next = S_TRANS;     end
      S_TRANS:     begin cmd.op = ddo_pkg::OP_TRANS;     state_next = S_ROT;       end
      S_ROT:       begin cmd.op = ddo_pkg::OP_ROT;       state_next = S_UNITS;     end
      S_UNITS:     begin cmd.op = ddo_pkg::OP_UNITS;     state_next = S_FWD;       end
      S_FWD:       begin cmd.op = ddo_pkg::OP_FWD;       state_next = S_ANG;       end
      S_ANG:       begin cmd.op = ddo_pkg::OP_ANG;       state_next = S_MID;       end
      S_MID:       begin cmd.op = ddo_pkg::OP_MID;       state_next = S_MID_WAIT;  end
      S_MID_WAIT:  if (status.cordic_done) state_next = S_POS_X;
      S_POS_X:     begin cmd.op = ddo_pkg::OP_POS_X;     state_next = S_POS_Y;     end
      S_POS_Y:     begin cmd.op = ddo_pkg::OP_POS_Y;     state_next = S_HEAD;      end
      S_HEAD:      begin cmd.op = ddo_pkg::OP_HEAD;      state_next = S_QUAT;      end
      S_QUAT:      begin cmd.op = ddo_pkg::OP_QUAT;      state_next = S_QUAT_WAIT; end
      S_QUAT_WAIT: if (status.cordic_done) state_next = S_LOAD;
      S_LOAD: begin
        // Hold the finished result until the output register is free.
        if (!status.out_busy) begin
          cmd.op     = ddo_pkg::OP_LOAD;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The output register is only loaded when it is free.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
      (cmd.op == ddo_pkg::OP_LOAD) |-> !status.out_busy)
    else $error("result loaded over a pending beat");

  // CORDIC completion only arrives while the controller waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
      status.cordic_done |-> (state == S_MID_WAIT || state == S_QUAT_WAIT))
    else $error("cordic finished outside a wait state");

  // A captured beat is always followed by dispatch.
  a_dispatch: assert property (@(posedge clk) disable iff (rst)
      (cmd.op == ddo_pkg::OP_CAPTURE) |=> (state == S_DISPATCH))
    else $error("capture not followed by dispatch");

endmodule

FILE: rtl/core/diff_drive_odometry.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Differential-drive wheel targets and odometry in Q15.16 fixed point.
//
// Channel  Direction  Handshake              Content
// s_*      in         s_tvalid / s_tready    speed command or tick with wheel angles
// m_*      out        m_tvalid / m_tready    targets, pose, quaternion, velocities
// cfg_*    in         cfg_valid / cfg_ready  register index and write data
//
// A command beat runs capture, dispatch, the command steps, the quaternion rotation
// and the load; a tick beat runs the update steps, midpoint rotation included, instead.
// The time taken is set by the iterative CORDIC, run once for the midpoint heading
// and once for the quaternion, and by the single shared multiplier.
// Reset is synchronous; working registers and the output data are not reset.
// The output register lets the next beat be accepted while a result waits;
// a result stalled downstream holds the controller before its next load.
// ----------------------------------------------------------------------------
module diff_drive_odometry #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // linear_speed[31:0], turn_rate[63:32], left_angle[95:64], right_angle[127:96]
  input  logic [ddo_pkg::IN_DATA_W-1:0]      s_tdata,
  // kind
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // left_drive[31:0], right_drive[63:32], expired[64], pose_x[96:65],
  // pose_y[128:97], heading_out[146:129], quat_z[164:147], quat_w[182:165],
  // forward_velocity[214:183], angular_velocity[246:215], zero pad[247]
  output logic [ddo_pkg::OUT_DATA_W-1:0]     m_tdata,
  // from_tick
  output logic                               m_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ddo_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]     cfg_data
);

  ddo_pkg::ddo_cmd_t    cmd;
  ddo_pkg::ddo_status_t status;

  // Controller.
  ddo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath.
  ddo_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
